### rtl/core/rphr_pkg.sv
// Shared types and constants for the R-peak heart rate detector.
package rphr_pkg;

    localparam int SMP_W          = 16;
    localparam int CFG_W          = 16;
    localparam int RR_W           = 16;
    localparam int MS_W           = 12;
    localparam int HR_W           = 8;
    localparam int DIV_W          = 32;
    localparam int DIV_CNT_W      = $clog2(DIV_W + 1);
    localparam int P60_W          = 22;
    localparam int RING_DEPTH_DEF = 8;

    localparam logic [5:0]       C_BPM_SCALE = 6'd60;
    localparam logic [9:0]       C_MS_PER_S  = 10'd1000;
    localparam logic [DIV_W-1:0] C_REFR_DIV  = DIV_W'(1000);
    localparam logic [DIV_W-1:0] C_REFR_RND  = DIV_W'(999);
    localparam logic [DIV_W-1:0] C_BPM_MIN   = DIV_W'(30);
    localparam logic [DIV_W-1:0] C_BPM_MAX   = DIV_W'(220);
    localparam logic [DIV_W-1:0] C_RR_MAX    = DIV_W'(65535);
    localparam logic [DIV_W-1:0] C_HR_MAX    = DIV_W'(255);
    localparam logic [DIV_W-1:0] C_MS_MAX    = DIV_W'(4095);

    typedef enum logic [1:0] {
        REG_SAMPLE_RATE = 2'd0,
        REG_HIGH_THR    = 2'd1,
        REG_LOW_THR     = 2'd2,
        REG_REFR_MS     = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic        [CFG_W-1:0] sample_rate;
        logic signed [CFG_W-1:0] high_thr;
        logic signed [CFG_W-1:0] low_thr;
        logic        [CFG_W-1:0] refr_ms;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic            wr;
        logic [RR_W-1:0] rr;
    } t_ring_req;

endpackage

### rtl/core/r_peak_heart_rate_detector_top.sv
// Top level of the R-peak detector with heart rate averaging.
// A sample is taken in S_IDLE and its result is loaded into the output register in S_DONE.
// A new sample is accepted only after the previous result is loaded, so output stalls hold input too.
// A peak with a kept interval runs four 32-step serial divisions, one quotient bit per cycle.
// Reset is synchronous, active low; the interval ring contents are not cleared.
module r_peak_heart_rate_detector_top #(
    parameter int RING_DEPTH = rphr_pkg::RING_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_idx,
    input  logic [rphr_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [rphr_pkg::SMP_W-1:0] i_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_peak_found,
    output logic [rphr_pkg::MS_W-1:0]         o_interval_ms,
    output logic [rphr_pkg::HR_W-1:0]         o_heart_rate
);
    import rphr_pkg::*;

    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int TOT_W  = RR_W + FILL_W;

    t_cfg              r_cfg;
    t_div_req          w_div_req;
    t_div_rsp          w_div_rsp;
    t_ring_req         w_ring_req;
    logic [TOT_W-1:0]  w_ring_total;
    logic [FILL_W-1:0] w_ring_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_SAMPLE_RATE: r_cfg.sample_rate <= i_cfg_wdata;
                REG_HIGH_THR:    r_cfg.high_thr    <= i_cfg_wdata;
                REG_LOW_THR:     r_cfg.low_thr     <= i_cfg_wdata;
                REG_REFR_MS:     r_cfg.refr_ms     <= i_cfg_wdata;
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    rphr_seq #(
        .FILL_W (FILL_W),
        .TOT_W  (TOT_W)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_sample      (i_sample),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_peak_found  (o_peak_found),
        .o_interval_ms (o_interval_ms),
        .o_heart_rate  (o_heart_rate),
        .o_div_req     (w_div_req),
        .i_div_rsp     (w_div_rsp),
        .o_ring_req    (w_ring_req),
        .i_ring_total  (w_ring_total),
        .i_ring_fill   (w_ring_fill)
    );

    rphr_serial_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    rphr_ring #(
        .RING_DEPTH (RING_DEPTH),
        .FILL_W     (FILL_W),
        .TOT_W      (TOT_W)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_ring_req),
        .o_total (w_ring_total),
        .o_fill  (w_ring_fill)
    );

endmodule

### rtl/core/rphr_serial_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module rphr_serial_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rphr_pkg::t_div_req i_req,
    output rphr_pkg::t_div_rsp o_rsp
);
    import rphr_pkg::*;

    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_quo;
    logic [DIV_W-1:0]     r_dvs;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_done;

    logic [DIV_W:0] w_trial;
    logic [DIV_W:0] w_diff;
    logic           w_ge;

    // shift the next dividend bit into the partial remainder
    assign w_trial = {r_rem, r_quo[DIV_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = !w_diff[DIV_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_cnt  <= DIV_CNT_W'(DIV_W);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == DIV_CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
        end
    end

    assign o_rsp.busy = (r_cnt != '0);
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

### rtl/core/rphr_ring.sv
// Ring of kept RR intervals with running total and fill count.
module rphr_ring #(
    parameter int RING_DEPTH = rphr_pkg::RING_DEPTH_DEF,
    parameter int FILL_W     = $clog2(RING_DEPTH + 1),
    parameter int TOT_W      = rphr_pkg::RR_W + FILL_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rphr_pkg::t_ring_req i_req,
    output logic [TOT_W-1:0]    o_total,
    output logic [FILL_W-1:0]   o_fill
);
    import rphr_pkg::*;

    localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    logic [RR_W-1:0]   r_mem [RING_DEPTH];
    logic [RR_W-1:0]   r_old;
    logic [SLOT_W-1:0] r_slot;
    logic [FILL_W-1:0] r_fill;
    logic [TOT_W-1:0]  r_total;
    logic              w_full;

    assign w_full = (r_fill == FILL_W'(RING_DEPTH));

    // the entry under the write slot is read ahead; the slot moves only on a write
    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            r_mem[r_slot] <= i_req.rr;
        end
        r_old <= r_mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_fill  <= '0;
            r_total <= '0;
        end else if (i_req.wr) begin
            if (w_full) begin
                r_total <= r_total - TOT_W'(r_old) + TOT_W'(i_req.rr);
            end else begin
                r_fill  <= r_fill + 1'b1;
                r_total <= r_total + TOT_W'(i_req.rr);
            end
            r_slot <= (r_slot == SLOT_W'(RING_DEPTH - 1)) ? '0 : r_slot + 1'b1;
        end
    end

    assign o_total = r_total;
    assign o_fill  = r_fill;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.wr |=> (r_fill != '0) && (r_fill <= FILL_W'(RING_DEPTH)))
        else $error("ring fill out of range after write");

endmodule

### rtl/core/rphr_seq.sv
// Per-sample sequencer: peak detection, interval checks, division schedule, result register.
module rphr_seq #(
    parameter int FILL_W = 4,
    parameter int TOT_W  = 20
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rphr_pkg::t_cfg                    i_cfg,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [rphr_pkg::SMP_W-1:0] i_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_peak_found,
    output logic [rphr_pkg::MS_W-1:0]         o_interval_ms,
    output logic [rphr_pkg::HR_W-1:0]         o_heart_rate,
    output rphr_pkg::t_div_req                o_div_req,
    input  rphr_pkg::t_div_rsp                i_div_rsp,
    output rphr_pkg::t_ring_req               o_ring_req,
    input  logic [TOT_W-1:0]                  i_ring_total,
    input  logic [FILL_W-1:0]                 i_ring_fill
);
    import rphr_pkg::*;

    localparam int PRD_W = P60_W + FILL_W;
    localparam int MSN_W = RR_W + 10;

    typedef enum logic [3:0] {
        S_IDLE, S_EVAL, S_REFR, S_REFR_WAIT, S_FIRE, S_BPM, S_BPM_WAIT,
        S_AVG_MUL, S_AVG, S_AVG_WAIT, S_MS, S_MS_WAIT, S_DONE
    } t_state;

    t_state                  r_state;
    logic signed [SMP_W-1:0] r_smp;
    logic                    r_armed;
    logic                    r_have_peak;
    logic [DIV_W-1:0]        r_count;
    logic [DIV_W-1:0]        r_last;
    logic [DIV_W-1:0]        r_pos;
    logic [DIV_W-1:0]        r_elapsed;
    logic [DIV_W-1:0]        r_prod;
    logic [HR_W-1:0]         r_avg;
    logic                    r_res_peak;
    logic [MS_W-1:0]         r_res_ms;
    logic                    r_dis;
    logic                    r_out_valid;
    logic                    r_out_peak;
    logic [MS_W-1:0]         r_out_ms;
    logic [HR_W-1:0]         r_out_hr;

    logic             w_armed_n;
    logic             w_hit;
    logic [DIV_W-1:0] w_refr;
    logic             w_bpm_ok;
    logic [P60_W-1:0] w_p60;
    logic [PRD_W-1:0] w_avg_prod;
    logic [MSN_W-1:0] w_ms_num;

    assign w_armed_n  = r_armed || (r_smp <= i_cfg.low_thr);
    assign w_hit      = w_armed_n && (r_smp >= i_cfg.high_thr);
    assign w_refr     = (i_div_rsp.quot > C_RR_MAX) ? C_RR_MAX : i_div_rsp.quot;
    assign w_bpm_ok   = (i_div_rsp.quot >= C_BPM_MIN) && (i_div_rsp.quot <= C_BPM_MAX);
    assign w_p60      = P60_W'(i_cfg.sample_rate) * P60_W'(C_BPM_SCALE);
    assign w_avg_prod = PRD_W'(w_p60) * PRD_W'(i_ring_fill);
    assign w_ms_num   = MSN_W'(r_elapsed[RR_W-1:0]) * MSN_W'(C_MS_PER_S);

    always_comb begin
        o_div_req = '0;
        unique case (r_state)
            S_REFR: begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = r_prod + C_REFR_RND;
                o_div_req.divisor  = C_REFR_DIV;
            end
            S_BPM: begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = DIV_W'(w_p60) + (r_elapsed >> 1);
                o_div_req.divisor  = r_elapsed;
            end
            S_AVG: begin
                o_div_req.start    = (i_ring_total != '0);
                o_div_req.dividend = r_prod + DIV_W'(i_ring_total >> 1);
                o_div_req.divisor  = DIV_W'(i_ring_total);
            end
            S_MS: begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = DIV_W'(w_ms_num) + DIV_W'(i_cfg.sample_rate >> 1);
                o_div_req.divisor  = DIV_W'(i_cfg.sample_rate);
            end
            default: begin
                o_div_req = '0;
            end
        endcase
    end

    assign o_ring_req.wr = (r_state == S_BPM_WAIT) && i_div_rsp.done && w_bpm_ok;
    assign o_ring_req.rr = r_elapsed[RR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_armed     <= 1'b1;
            r_have_peak <= 1'b0;
            r_count     <= '0;
            r_last      <= '0;
            r_avg       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // drop the taken item; S_DONE loads the next one itself
            if (i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_smp   <= i_sample;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_res_peak <= 1'b0;
                    r_res_ms   <= '0;
                    if (i_cfg.sample_rate == '0) begin
                        // disabled: zeros out, state untouched
                        r_dis   <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_dis     <= 1'b0;
                        r_armed   <= w_armed_n;
                        r_elapsed <= r_count - r_last;
                        r_pos     <= r_count;
                        r_count   <= r_count + 1'b1;
                        r_prod    <= DIV_W'(i_cfg.sample_rate) * DIV_W'(i_cfg.refr_ms);
                        if (!w_hit) begin
                            r_state <= S_DONE;
                        end else if (r_have_peak) begin
                            r_state <= S_REFR;
                        end else begin
                            r_state <= S_FIRE;
                        end
                    end
                end
                S_REFR: begin
                    r_state <= S_REFR_WAIT;
                end
                S_REFR_WAIT: begin
                    if (i_div_rsp.done) begin
                        r_state <= (r_elapsed >= w_refr) ? S_FIRE : S_DONE;
                    end
                end
                S_FIRE: begin
                    r_res_peak  <= 1'b1;
                    r_armed     <= 1'b0;
                    r_have_peak <= 1'b1;
                    r_last      <= r_pos;
                    // a wrapped zero interval or one too long is never kept
                    if (r_have_peak && (r_elapsed != '0) && (r_elapsed <= C_RR_MAX)) begin
                        r_state <= S_BPM;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_BPM: begin
                    r_state <= S_BPM_WAIT;
                end
                S_BPM_WAIT: begin
                    if (i_div_rsp.done) begin
                        r_state <= w_bpm_ok ? S_AVG_MUL : S_DONE;
                    end
                end
                S_AVG_MUL: begin
                    r_prod  <= DIV_W'(w_avg_prod);
                    r_state <= S_AVG;
                end
                S_AVG: begin
                    r_state <= (i_ring_total != '0) ? S_AVG_WAIT : S_MS;
                end
                S_AVG_WAIT: begin
                    if (i_div_rsp.done) begin
                        r_avg   <= (i_div_rsp.quot > C_HR_MAX) ? HR_W'(C_HR_MAX)
                                                            : i_div_rsp.quot[HR_W-1:0];
                        r_state <= S_MS;
                    end
                end
                S_MS: begin
                    r_state <= S_MS_WAIT;
                end
                S_MS_WAIT: begin
                    if (i_div_rsp.done) begin
                        r_res_ms <= (i_div_rsp.quot > C_MS_MAX) ? MS_W'(C_MS_MAX)
                                                              : i_div_rsp.quot[MS_W-1:0];
                        r_state  <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold until the result register is free
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_peak  <= r_res_peak;
                        r_out_ms    <= r_res_ms;
                        r_out_hr    <= r_dis ? '0 : r_avg;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_peak_found  = r_out_peak;
    assign o_interval_ms = r_out_ms;
    assign o_heart_rate  = r_out_hr;

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_div_req.start |-> !i_div_rsp.busy)
        else $error("division started while divider busy");

    a_ring_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ring_req.wr |-> (o_ring_req.rr != '0))
        else $error("zero interval written to ring");

    a_ms_needs_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_ms != '0)) |-> r_out_peak)
        else $error("interval reported without a peak");

    a_fire_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIRE) |=> (!r_armed && r_have_peak))
        else $error("peak did not disarm detector");

endmodule

### test/tb_top.sv
// Testbench for the R-peak heart rate detector: directed cases and random beat trains checked against a predictor.
`timescale 1ns / 1ps

module tb_top;
    import rphr_pkg::*;

    localparam int RING        = 8;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic              peak;
        logic [MS_W-1:0]   ms;
        logic [HR_W-1:0]   hr;
    } t_beat;

    typedef enum {LVL_LOW, LVL_MID, LVL_HIGH, LVL_ANY} t_level;

    class t_beat_checker;
        logic        [CFG_W-1:0] rate;
        logic signed [CFG_W-1:0] hi_thr;
        logic signed [CFG_W-1:0] lo_thr;
        logic        [CFG_W-1:0] refr_ms;

        logic              armed;
        logic              seen_peak;
        logic [31:0]       n_samples;
        logic [31:0]       last_peak;
        logic [RR_W-1:0]   rr_ring [RING];
        logic [2:0]        slot;
        logic [3:0]        fill;
        logic [19:0]       rr_sum;
        logic [HR_W-1:0]   avg_bpm;

        t_beat expected_beats [$];
        int    errors;

        function new();
            rate      = '0;
            hi_thr    = '0;
            lo_thr    = '0;
            refr_ms   = '0;
            armed     = 1'b1;
            seen_peak = 1'b0;
            n_samples = '0;
            last_peak = '0;
            foreach (rr_ring[k]) rr_ring[k] = '0;
            slot      = '0;
            fill      = '0;
            rr_sum    = '0;
            avg_bpm   = '0;
            errors    = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [CFG_W-1:0] v);
            case (idx)
                REG_SAMPLE_RATE: rate    = v;
                REG_HIGH_THR:    hi_thr  = v;
                REG_LOW_THR:     lo_thr  = v;
                REG_REFR_MS:     refr_ms = v;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        // ceil(rate * ms / 1000), saturated to 16 bits
        function logic [31:0] refractory();
            longint unsigned r;
            r = (64'(rate) * 64'(refr_ms) + 64'd999) / 64'd1000;
            return (r > 64'd65535) ? 32'd65535 : 32'(r);
        endfunction

        function logic [MS_W-1:0] store_interval(logic [RR_W-1:0] rr);
            longint unsigned q;
            if (fill >= 4'(RING)) begin
                rr_sum -= 20'(rr_ring[slot]);
            end else begin
                fill++;
            end
            rr_ring[slot] = rr;
            rr_sum += 20'(rr);
            slot++;
            if (rr_sum != 0) begin
                q = (64'd60 * 64'(rate) * 64'(fill) + 64'(rr_sum) / 2) / 64'(rr_sum);
                avg_bpm = (q > 64'd255) ? 8'd255 : 8'(q);
            end
            q = (64'(rr) * 64'd1000 + 64'(rate) / 2) / 64'(rate);
            return (q > 64'd4095) ? 12'd4095 : 12'(q);
        endfunction

        function void note_sample(logic signed [SMP_W-1:0] s);
            t_beat           exp_b;
            logic [31:0]     gap;
            longint unsigned bpm;
            exp_b = '0;
            if (rate == 0) begin
                // disabled: zeros out, state frozen
                expected_beats.push_back(exp_b);
                return;
            end
            gap = n_samples - last_peak;
            if (s <= lo_thr) armed = 1'b1;
            if (armed && s >= hi_thr && (!seen_peak || gap >= refractory())) begin
                exp_b.peak = 1'b1;
                armed      = 1'b0;
                if (seen_peak && gap != 0) begin
                    bpm = (64'd60 * 64'(rate) + 64'(gap) / 2) / 64'(gap);
                    if (bpm >= 64'd30 && bpm <= 64'd220 && gap <= 32'd65535)
                        exp_b.ms = store_interval(gap[RR_W-1:0]);
                end
                last_peak = n_samples;
                seen_peak = 1'b1;
            end
            n_samples++;
            exp_b.hr = avg_bpm;
            expected_beats.push_back(exp_b);
        endfunction

        function void flag(string what, logic [31:0] exp_v, logic [31:0] got_v);
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, exp_v, got_v);
        endfunction

        function void check_beat(logic peak, logic [MS_W-1:0] ms, logic [HR_W-1:0] hr);
            t_beat exp_b;
            if (expected_beats.size() == 0) begin
                errors++;
                $display("%0t: result with no sample pending, expected none actual %0d/%0d/%0d",
                         $time, peak, ms, hr);
                return;
            end
            exp_b = expected_beats.pop_front();
            if (peak !== exp_b.peak) flag("peak_found", 32'(exp_b.peak), 32'(peak));
            if (ms !== exp_b.ms)     flag("interval_ms", 32'(exp_b.ms), 32'(ms));
            if (hr !== exp_b.hr)     flag("heart_rate", 32'(exp_b.hr), 32'(hr));
        endfunction
    endclass

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_cfg_we    = 1'b0;
    logic [1:0]              i_cfg_idx   = '0;
    logic [CFG_W-1:0]        i_cfg_wdata = '0;
    logic                    i_in_valid  = 1'b0;
    logic                    o_in_ready;
    logic signed [SMP_W-1:0] i_sample    = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic                    o_peak_found;
    logic [MS_W-1:0]         o_interval_ms;
    logic [HR_W-1:0]         o_heart_rate;

    t_beat_checker beats = new();
    int            burst_left = 0;
    int            stall_mode = 0;
    int            stall_left = 0;
    int            stall_cyc = 0;
    int            cycle_count = 0;

    r_peak_heart_rate_detector_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_sample      (i_sample),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_peak_found  (o_peak_found),
        .o_interval_ms (o_interval_ms),
        .o_heart_rate  (o_heart_rate)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: check accepted items, then pick the next ready level.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            beats.check_beat(o_peak_found, o_interval_ms, o_heart_rate);
        if (stall_left == 0) begin
            stall_mode = $urandom_range(3);
            stall_left = 64 + $urandom_range(256);
        end
        stall_left--;
        stall_cyc++;
        if (stall_mode == 0)
            i_out_ready <= 1'b1;
        else if (stall_mode == 1)
            i_out_ready <= 1'($urandom_range(1));
        else if (stall_mode == 2)
            i_out_ready <= ($urandom_range(3) == 0);
        else
            i_out_ready <= ((stall_cyc % 7) < 3);
    end

    function automatic int rand_between(int lo, int hi);
        if (hi <= lo) return lo;
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic t_cfg make_cfg(int rate, int hi, int lo, int refr);
        t_cfg c;
        c.sample_rate = CFG_W'(rate);
        c.high_thr    = CFG_W'(hi);
        c.low_thr     = CFG_W'(lo);
        c.refr_ms     = CFG_W'(refr);
        return c;
    endfunction

    function automatic logic signed [SMP_W-1:0] pick_level(t_level lv);
        int lo_i;
        int hi_i;
        lo_i = beats.lo_thr;
        hi_i = beats.hi_thr;
        case (lv)
            LVL_LOW:  return SMP_W'(rand_between(-32768, lo_i));
            LVL_HIGH: return SMP_W'(rand_between(hi_i, 32767));
            LVL_MID:  return SMP_W'(rand_between(lo_i + 1, hi_i - 1));
            default:  return SMP_W'($urandom());
        endcase
    endfunction

    // Call at a rising edge; returns at the edge where the item was taken.
    task automatic push_sample(input logic signed [SMP_W-1:0] s);
        if (burst_left == 0) begin
            burst_left = 1 + $urandom_range(24);
            if ($urandom_range(3) != 0) begin
                i_in_valid <= 1'b0;
                repeat (1 + $urandom_range(6)) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_sample   <= s;
        do @(posedge i_clk); while (!o_in_ready);
        beats.note_sample(s);
    endtask

    task automatic wait_drained(input int settle);
        i_in_valid <= 1'b0;
        while (beats.pending() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic apply_config(input t_cfg c, input logic [3:0] mask);
        t_reg_idx         idx;
        logic [CFG_W-1:0] v;
        for (int k = 0; k < 4; k++) begin
            if (mask[k]) begin
                idx = t_reg_idx'(k);
                case (idx)
                    REG_SAMPLE_RATE: v = c.sample_rate;
                    REG_HIGH_THR:    v = c.high_thr;
                    REG_LOW_THR:     v = c.low_thr;
                    default:         v = c.refr_ms;
                endcase
                i_cfg_we    <= 1'b1;
                i_cfg_idx   <= idx;
                i_cfg_wdata <= v;
                @(posedge i_clk);
                beats.set_reg(idx, v);
            end
        end
        i_cfg_we <= 1'b0;
    endtask

    // Beat trains: a high to fire, a low to re-arm, filler in between,
    // with stray highs, lows and noise mixed in.
    task automatic send_beats(input int n_items);
        int          sent;
        int          period;
        int          pmin;
        int          pmax;
        int unsigned r;
        t_level      lv;
        sent = 0;
        if (beats.rate <= 40) begin
            pmin = (60 * beats.rate) / 240;
            pmax = (60 * beats.rate) / 25 + 2;
        end else begin
            pmin = 2;
            pmax = 40;
        end
        if (pmin < 2) pmin = 2;
        while (sent < n_items) begin
            period = rand_between(pmin, pmax);
            for (int k = 0; k < period && sent < n_items; k++) begin
                r = $urandom_range(99);
                if (k == 0)
                    lv = (r < 90) ? LVL_HIGH : LVL_MID;
                else if (k == 1)
                    lv = (r < 85) ? LVL_LOW : LVL_MID;
                else if (r < 8)
                    lv = LVL_LOW;
                else if (r < 11)
                    lv = LVL_HIGH;
                else if (r < 16)
                    lv = LVL_ANY;
                else
                    lv = LVL_MID;
                push_sample(pick_level(lv));
                sent++;
            end
        end
    endtask

    initial begin
        t_cfg        cfg;
        logic [3:0]  mask;
        int          random_items;
        int          n;
        int          r;
        int          lo_v;
        int          hi_v;
        random_items = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // registers still at reset: rate zero gives all-zero results
        push_sample(16'sh7FFF);
        push_sample(16'sh8000);
        push_sample(16'sd0);
        wait_drained(8);

        // 10 Hz, refractory 400 ms = 4 samples
        apply_config(make_cfg(10, 1000, -1000, 400), 4'hF);
        push_sample(16'sh7FFF);   // first peak
        push_sample(16'sh7FFF);   // still disarmed
        push_sample(16'sh8000);   // re-arm
        push_sample(16'sd1000);   // at threshold, inside refractory
        push_sample(16'sd1000);   // fires, 150 bpm kept
        push_sample(-16'sd1000);  // re-arm exactly at low threshold
        push_sample(16'sd0);
        push_sample(16'sh8000);
        push_sample(16'sh7FFF);   // fires again
        wait_drained(8);

        // 1 Hz and thresholds at the extremes: every sample fires, 60 bpm each
        apply_config(make_cfg(1, -32768, 32767, 0), 4'hF);
        send_beats(40);
        wait_drained(8);

        // largest rate and refractory time, saturated refractory interval
        apply_config(make_cfg(65535, 32767, -32768, 65535), 4'hF);
        send_beats(30);
        wait_drained(8);

        // disable, then come back with state untouched
        apply_config(make_cfg(0, 0, 0, 0), 4'b0001);
        send_beats(20);

        while (random_items < 900) begin
            wait_drained(8);
            r = $urandom_range(99);
            if (r < 70)
                cfg.sample_rate = CFG_W'(rand_between(2, 30));
            else if (r < 85)
                cfg.sample_rate = CFG_W'(rand_between(31, 500));
            else if (r < 95)
                cfg.sample_rate = CFG_W'(rand_between(1, 65535));
            else
                cfg.sample_rate = '0;
            if ($urandom_range(9) < 2) begin
                lo_v = rand_between(-32768, 32767);
                hi_v = rand_between(-32768, 32767);
            end else begin
                lo_v = -rand_between(0, 8000);
                hi_v = rand_between(200, 8200);
            end
            cfg.low_thr  = CFG_W'(lo_v);
            cfg.high_thr = CFG_W'(hi_v);
            r = $urandom_range(9);
            if (r < 6)
                cfg.refr_ms = CFG_W'(rand_between(0, 600));
            else if (r < 8)
                cfg.refr_ms = '0;
            else
                cfg.refr_ms = CFG_W'($urandom_range(65535));
            mask = ($urandom_range(9) < 7) ? 4'hF : 4'(1 + $urandom_range(14));
            apply_config(cfg, mask);
            n = 40 + $urandom_range(80);
            send_beats(n);
            random_items += n;
        end

        wait_drained(200);
        if (beats.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

### files.f
rtl/core/rphr_pkg.sv
rtl/core/rphr_serial_div.sv
rtl/core/rphr_ring.sv
rtl/core/rphr_seq.sv
rtl/core/r_peak_heart_rate_detector_top.sv
test/tb_top.sv
